// ===== sv/waypoint_steering_follower_defines.svh =====
// assertion macros for the waypoint steering follower
// no dependencies; included by the top level only
`ifndef WAYPOINT_STEERING_FOLLOWER_DEFINES_SVH
`define WAYPOINT_STEERING_FOLLOWER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsf assertion failed");

// next-cycle implication, disabled while reset is low
`define WSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsf assertion failed");

`endif

// ===== sv/wsf_pkg.sv =====
// shared types and constants for the waypoint steering follower
// no dependencies
package wsf_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LOAD   = 2'd0;
    localparam t_cmd CMD_SAMPLE = 2'd1;
    localparam t_cmd CMD_MODE   = 2'd2;

    // register index is address bit 2
    localparam logic REG_ARRIVE  = 1'b0;
    localparam logic REG_REFRESH = 1'b1;

    localparam int ADDR_W = 3;

    localparam logic [15:0] ARRIVE_RESET  = 16'd1536;
    localparam logic [15:0] REFRESH_RESET = 16'd205;

    localparam int         STEER_LIMIT = 28;
    localparam logic [3:0] THROTTLE    = 4'd6;

    // sin^2(k degrees) * 2^32, k = 1..28
    localparam logic [29:0] SINSQ [STEER_LIMIT] = '{
        30'd1308189,   30'd5231162,   30'd11764140,  30'd20899163,
        30'd32625102,  30'd46927670,  30'd63789442,  30'd83189875,
        30'd105105331, 30'd129509111, 30'd156371482, 30'd185659716,
        30'd217338131, 30'd251368130, 30'd287707255, 30'd326314229,
        30'd367139017, 30'd410132882, 30'd455243440, 30'd502415733,
        30'd551592287, 30'd602713189, 30'd655716156, 30'd710536612,
        30'd767107767, 30'd825360697, 30'd885224430, 30'd946626032
    };

endpackage

// ===== sv/wsf_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// no dependencies
module wsf_mul #(
    parameter int WA = 82,
    parameter int WB = 164
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p,
    output logic             o_done
);
    localparam int WP   = WA + WB;
    localparam int CNTW = $clog2(WB + 1);

    logic [WP-1:0]   r_p;
    logic [WA-1:0]   r_a;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;
    logic [WA:0]     s;

    // upper WA bits plus multiplicand when the low bit is set
    assign s = {1'b0, r_p[WP-1:WB]} + (r_p[0] ? {1'b0, r_a} : {(WA+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run) begin
            if (r_cnt == CNTW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p   <= {{WA{1'b0}}, i_b};
            r_a   <= i_a;
            r_cnt <= CNTW'(WB);
        end else if (r_run) begin
            r_p   <= {s, r_p[WB-1:1]};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

// ===== sv/waypoint_steering_follower.sv =====
// waypoint steering follower: all sample products go through one bit-serial multiplier;
// a sample needs 4 products outside base mode and up to 36 in base mode, plus 2 per stored
// waypoint on the first sample (nearest-point scan)
// one item at a time, busy high while a sample is worked; loads, mode changes and ignored
// commands do not raise busy; results strobe o_valid for one cycle, receiver cannot stall
// synchronous active-low reset clears table count, target, previous position and mode
`include "waypoint_steering_follower_defines.svh"

module waypoint_steering_follower #(
    parameter int MAX_WAYPOINTS = 1024,
    parameter int POS_WIDTH     = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  wsf_pkg::t_cmd                 i_cmd,
    input  logic signed [POS_WIDTH-1:0]   i_coord_x,
    input  logic signed [POS_WIDTH-1:0]   i_coord_y,
    input  logic [7:0]                    i_mode_value,
    output logic                          o_valid,
    output logic signed [5:0]             o_steering,
    output logic [3:0]                    o_throttle,
    output logic [9:0]                    o_target_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import wsf_pkg::*;

    localparam int D    = POS_WIDTH + 1;   // coordinate difference
    localparam int SQ_W = 2 * D;           // squared distance, cross magnitude
    localparam int WA   = 2 * D;           // multiplicand
    localparam int WB   = 4 * D;           // multiplier (serial)
    localparam int WP   = WA + WB;
    localparam int AW   = $clog2(MAX_WAYPOINTS);
    localparam int CW   = $clog2(MAX_WAYPOINTS + 1);
    localparam int IW   = (AW > 10) ? AW : 10;
    localparam int LAST_K = STEER_LIMIT - 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SC_RD = 4'd1;   // scan: read waypoint
    localparam logic [3:0] ST_SC_X  = 4'd2;   // scan: dx^2
    localparam logic [3:0] ST_SC_Y  = 4'd3;   // scan: dy^2, keep nearest
    localparam logic [3:0] ST_T_RD  = 4'd4;   // read target waypoint
    localparam logic [3:0] ST_AX    = 4'd5;   // heading length squared
    localparam logic [3:0] ST_AY    = 4'd6;
    localparam logic [3:0] ST_BX    = 4'd7;   // target length squared
    localparam logic [3:0] ST_BY    = 4'd8;
    localparam logic [3:0] ST_C1    = 4'd9;   // cross product terms
    localparam logic [3:0] ST_C2    = 4'd10;
    localparam logic [3:0] ST_CC    = 4'd11;  // c^2
    localparam logic [3:0] ST_AB    = 4'd12;  // A*B
    localparam logic [3:0] ST_SK    = 4'd13;  // sin^2 threshold sweep
    localparam logic [3:0] ST_FIN   = 4'd14;  // emit, advance target, refresh prev

    logic [3:0] r_state, n_state;
    logic       r_ph, n_ph;        // 0: launch product, 1: wait for it

    // architectural state
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_tgt;
    logic                         r_ready;
    logic signed [POS_WIDTH-1:0]  r_px, r_py;
    logic [7:0]                   r_mode;
    logic [15:0]                  r_arrive, r_refresh;

    // waypoint table, registered read
    logic [POS_WIDTH-1:0] mem_x [MAX_WAYPOINTS];
    logic [POS_WIDTH-1:0] mem_y [MAX_WAYPOINTS];
    logic [POS_WIDTH-1:0] r_wx, r_wy;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;

    // sample working registers
    logic signed [POS_WIDTH-1:0] r_cx, r_cy;
    logic [AW-1:0]   r_idx, r_best_i;
    logic [SQ_W-1:0] r_best, r_sq, r_asq, r_bsq, r_p1;
    logic            r_s1, r_neg;
    logic [SQ_W:0]   r_c;
    logic [WP-1:0]   r_lhs;
    logic [WB-1:0]   r_ab;
    logic [4:0]      r_k, r_mag;

    // result registers
    logic            r_valid;
    logic [5:0]      r_steer;
    logic [9:0]      r_tidx;

    // multiplier hookup
    logic            mul_go, mul_done, mul_state;
    logic [WA-1:0]   mul_a;
    logic [WB-1:0]   mul_b;
    logic [WP-1:0]   mul_p;
    logic            step_done;

    logic accept, smp_go;
    logic cfg_wr;

    // coordinate differences, sign extended to D bits
    logic [D-1:0] x1, y1, x2, y2, wdx, wdy;
    logic [D-1:0] ax1, ay1, ax2, ay2, awdx, awdy;
    logic [SQ_W-1:0] prod_sq, sc_d, cmag;
    logic            better, scan_last, ge;
    logic signed [SQ_W:0] sp1, sp2, c_new;
    logic [31:0]     arr2, ref2;
    logic [IW-1:0]   tgt_ext;
    logic            steer_ok;

    assign accept = start && !busy;
    assign smp_go = accept && (i_cmd == CMD_SAMPLE) && (r_count != '0);
    assign wr_en  = accept && (i_cmd == CMD_LOAD) && (r_count < CW'(MAX_WAYPOINTS));
    assign busy   = (r_state != ST_IDLE);

    assign x1  = {r_cx[POS_WIDTH-1], r_cx} - {r_px[POS_WIDTH-1], r_px};
    assign y1  = {r_cy[POS_WIDTH-1], r_cy} - {r_py[POS_WIDTH-1], r_py};
    assign x2  = {r_wx[POS_WIDTH-1], r_wx} - {r_cx[POS_WIDTH-1], r_cx};
    assign y2  = {r_wy[POS_WIDTH-1], r_wy} - {r_cy[POS_WIDTH-1], r_cy};
    assign wdx = x2;   // waypoint minus position, squared the same either way
    assign wdy = y2;

    assign ax1  = x1[D-1]  ? (~x1 + 1'b1)  : x1;
    assign ay1  = y1[D-1]  ? (~y1 + 1'b1)  : y1;
    assign ax2  = x2[D-1]  ? (~x2 + 1'b1)  : x2;
    assign ay2  = y2[D-1]  ? (~y2 + 1'b1)  : y2;
    assign awdx = ax2;
    assign awdy = ay2;

    assign cmag = r_c[SQ_W] ? SQ_W'(~r_c + 1'b1) : SQ_W'(r_c);

    assign prod_sq   = mul_p[SQ_W-1:0];
    assign step_done = r_ph && mul_done;

    // nearest-point scan, lowest index wins a tie
    assign sc_d      = r_sq + prod_sq;
    assign better    = (r_idx == '0) || (sc_d < r_best);
    assign scan_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // signed cross product from magnitudes and signs
    assign sp1   = r_s1 ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign sp2   = (y1[D-1] ^ x2[D-1]) ? -$signed({1'b0, prod_sq}) : $signed({1'b0, prod_sq});
    assign c_new = sp1 - sp2;

    assign ge   = (r_lhs >= mul_p);
    assign arr2 = {16'd0, r_arrive} * {16'd0, r_arrive};
    assign ref2 = {16'd0, r_refresh} * {16'd0, r_refresh};

    assign tgt_ext = IW'(r_tgt);

    // scan states walk the table, everything else reads the target
    assign rd_addr = ((r_state == ST_SC_RD) || (r_state == ST_SC_X) || (r_state == ST_SC_Y))
                     ? r_idx : r_tgt;

    // operand select for the shared multiplier
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_state = 1'b1;
        case (r_state)
            ST_SC_X: begin
                mul_a = WA'(awdx);
                mul_b = WB'(awdx);
            end
            ST_SC_Y: begin
                mul_a = WA'(awdy);
                mul_b = WB'(awdy);
            end
            ST_AX: begin
                mul_a = WA'(ax1);
                mul_b = WB'(ax1);
            end
            ST_AY: begin
                mul_a = WA'(ay1);
                mul_b = WB'(ay1);
            end
            ST_BX: begin
                mul_a = WA'(ax2);
                mul_b = WB'(ax2);
            end
            ST_BY: begin
                mul_a = WA'(ay2);
                mul_b = WB'(ay2);
            end
            ST_C1: begin
                mul_a = WA'(ax1);
                mul_b = WB'(ay2);
            end
            ST_C2: begin
                mul_a = WA'(ay1);
                mul_b = WB'(ax2);
            end
            ST_CC: begin
                mul_a = cmag;
                mul_b = WB'(cmag);
            end
            ST_AB: begin
                mul_a = r_asq;
                mul_b = WB'(r_bsq);
            end
            ST_SK: begin
                mul_a = WA'(SINSQ[r_k]);
                mul_b = r_ab;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign mul_go = mul_state && !r_ph;

    wsf_mul #(
        .WA (WA),
        .WB (WB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        case (r_state)
            ST_IDLE: begin
                n_ph = 1'b0;
                if (smp_go) begin
                    n_state = r_ready ? ST_T_RD : ST_SC_RD;
                end
            end
            ST_SC_RD: n_state = ST_SC_X;
            ST_T_RD:  n_state = ST_AX;
            ST_FIN:   n_state = ST_IDLE;
            default: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (mul_done) begin
                    n_ph = 1'b0;
                    case (r_state)
                        ST_SC_X: n_state = ST_SC_Y;
                        ST_SC_Y: n_state = scan_last ? ST_T_RD : ST_SC_RD;
                        ST_AX:   n_state = ST_AY;
                        ST_AY:   n_state = ST_BX;
                        ST_BX:   n_state = ST_BY;
                        ST_BY:   n_state = (r_mode != 8'd0) ? ST_FIN : ST_C1;
                        ST_C1:   n_state = ST_C2;
                        // a zero length gives straight ahead
                        ST_C2:   n_state = ((r_asq == '0) || (r_bsq == '0)) ? ST_FIN : ST_CC;
                        ST_CC:   n_state = ST_AB;
                        ST_AB:   n_state = ST_SK;
                        // thresholds rise with k, so the first miss ends the sweep
                        ST_SK:   n_state = (!ge || (r_k == 5'(LAST_K))) ? ST_FIN : ST_SK;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ph      <= 1'b0;
            r_count   <= '0;
            r_tgt     <= '0;
            r_ready   <= 1'b0;
            r_px      <= '0;
            r_py      <= '0;
            r_mode    <= 8'd0;
            r_arrive  <= ARRIVE_RESET;
            r_refresh <= REFRESH_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_valid <= 1'b0;

            if (cfg_wr) begin
                if (paddr[2] == REG_REFRESH) begin
                    r_refresh <= pwdata[15:0];
                end else begin
                    r_arrive <= pwdata[15:0];
                end
            end

            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (accept && (i_cmd == CMD_MODE)) begin
                r_mode <= i_mode_value;
            end

            // end of the first scan fixes the target
            if ((r_state == ST_SC_Y) && step_done && scan_last) begin
                r_ready <= 1'b1;
                r_tgt   <= better ? r_idx : r_best_i;
            end

            if (r_state == ST_FIN) begin
                r_valid <= (r_mode == 8'd0);
                // arrival: squared distance to target is B
                if ((r_bsq < SQ_W'(arr2)) && ((CW'(r_tgt) + CW'(1)) < r_count)) begin
                    r_tgt <= r_tgt + 1'b1;
                end
                // refresh: squared movement since prev is A
                if (r_asq > SQ_W'(ref2)) begin
                    r_px <= r_cx;
                    r_py <= r_cy;
                end
            end
        end
    end

    // table and sample datapath
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[AW-1:0]] <= i_coord_x;
            mem_y[r_count[AW-1:0]] <= i_coord_y;
        end
        r_wx <= mem_x[rd_addr];
        r_wy <= mem_y[rd_addr];

        case (r_state)
            ST_IDLE: begin
                if (smp_go) begin
                    r_cx  <= i_coord_x;
                    r_cy  <= i_coord_y;
                    r_idx <= '0;
                end
            end
            ST_SC_X, ST_AX, ST_BX: begin
                if (step_done) begin
                    r_sq <= prod_sq;
                end
            end
            ST_SC_Y: begin
                if (step_done) begin
                    if (better) begin
                        r_best   <= sc_d;
                        r_best_i <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            ST_T_RD: begin
                r_mag <= 5'd0;
                r_neg <= 1'b0;
            end
            ST_AY: begin
                if (step_done) begin
                    r_asq <= r_sq + prod_sq;
                end
            end
            ST_BY: begin
                if (step_done) begin
                    r_bsq <= r_sq + prod_sq;
                end
            end
            ST_C1: begin
                if (step_done) begin
                    r_p1 <= prod_sq;
                    r_s1 <= x1[D-1] ^ y2[D-1];
                end
            end
            ST_C2: begin
                if (step_done) begin
                    r_c   <= c_new;
                    r_neg <= c_new[SQ_W];
                end
            end
            ST_CC: begin
                if (step_done) begin
                    r_lhs <= {mul_p[WP-33:0], 32'd0};
                end
            end
            ST_AB: begin
                if (step_done) begin
                    r_ab <= mul_p[WB-1:0];
                    r_k  <= 5'd0;
                end
            end
            ST_SK: begin
                if (step_done && ge) begin
                    r_mag <= r_mag + 1'b1;
                    r_k   <= r_k + 1'b1;
                end
            end
            ST_FIN: begin
                r_steer <= r_neg ? (~6'(r_mag) + 1'b1) : 6'(r_mag);
                r_tidx  <= tgt_ext[9:0];
            end
            default: begin
            end
        endcase
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REFRESH) ? {16'd0, r_refresh} : {16'd0, r_arrive};

    // result port
    assign o_valid        = r_valid;
    assign o_steering     = r_steer;
    assign o_throttle     = THROTTLE;
    assign o_target_index = r_tidx;

    // checks
    assign steer_ok = ($signed(o_steering) <= 6'sd28) && ($signed(o_steering) >= -6'sd28);

    `WSF_ASSERT_IMPL(a_steer_range, i_clk, i_rst_n, o_valid, steer_ok)
    `WSF_ASSERT_IMPL(a_tgt_in_table, i_clk, i_rst_n, r_ready, (CW'(r_tgt) < r_count))
    `WSF_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, smp_go, busy)
    `WSF_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

// ===== dv/tb.sv =====
// testbench for waypoint_steering_follower: directed table, then random path-following phases
// depends on wsf_pkg and the rtl top level; self-checking against its own integer predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsf_pkg::*;

    localparam int     TABLE_DEPTH = 1024;
    localparam t_cmd   CMD_UNUSED  = 2'd3;
    localparam logic signed [39:0] COORD_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] COORD_MIN = 40'sh80_0000_0000;
    localparam int     STALL_LIMIT = 2000000;

    typedef struct {
        t_cmd               cmd;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic [7:0]         mode;
        bit                 typed;  // expected result written in the row
        logic signed [5:0]  steer;
        logic [9:0]         tidx;
    } t_item;

    typedef struct {
        logic signed [5:0] steer;
        logic [3:0]        throttle;
        logic [9:0]        tidx;
    } t_steer_cmd;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic signed [39:0] i_coord_x;
    logic signed [39:0] i_coord_y;
    logic [7:0] i_mode_value;
    logic o_valid;
    logic signed [5:0] o_steering;
    logic [3:0] o_throttle;
    logic [9:0] o_target_index;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    waypoint_steering_follower u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_mode_value   (i_mode_value),
        .o_valid        (o_valid),
        .o_steering     (o_steering),
        .o_throttle     (o_throttle),
        .o_target_index (o_target_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // follower state as the predictor sees it
    longint     wp_x [TABLE_DEPTH];
    longint     wp_y [TABLE_DEPTH];
    int         wp_count;
    int         target;
    bit         path_ready;
    longint     prev_x;
    longint     prev_y;
    logic [7:0] run_mode;
    logic [15:0] arrive_dist;
    logic [15:0] refresh_dist;

    t_steer_cmd steer_q[$];   // steering commands still owed by the block
    t_item      directed[$];
    int         mismatches;
    int         items_sent;
    int         results_seen;
    int         stall_cycles;
    bit         idle_on;
    longint     walk_x;
    longint     walk_y;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // squared distance, exact
    function automatic logic signed [255:0] dist2(longint ax, longint ay, longint bx, longint by);
        logic signed [255:0] dx;
        logic signed [255:0] dy;
        dx = 256'(ax - bx);
        dy = 256'(ay - by);
        return dx * dx + dy * dy;
    endfunction

    // heading error in whole degrees: count the sin^2 thresholds that the ratio reaches
    function automatic int heading_error(longint px, longint py, longint cx, longint cy,
                                         longint tx, longint ty);
        logic signed [255:0] x1;
        logic signed [255:0] y1;
        logic signed [255:0] x2;
        logic signed [255:0] y2;
        logic signed [255:0] len_h;
        logic signed [255:0] len_t;
        logic signed [255:0] cr_prod;
        logic signed [255:0] lhs;
        logic signed [255:0] ab;
        logic signed [255:0] thr;
        bit neg;
        int mag;
        x1 = 256'(cx - px);
        y1 = 256'(cy - py);
        x2 = 256'(tx - cx);
        y2 = 256'(ty - cy);
        len_h = x1 * x1 + y1 * y1;
        len_t = x2 * x2 + y2 * y2;
        cr_prod = x1 * y2 - y1 * x2;
        mag = 0;
        // zero length heading or target gives straight ahead
        if (len_h == 0 || len_t == 0) return 0;
        neg = cr_prod < 0;
        if (neg) cr_prod = -cr_prod;
        lhs = (cr_prod * cr_prod) <<< 32;
        ab = len_h * len_t;
        for (int k = 0; k < STEER_LIMIT; k++) begin
            thr = 256'(SINSQ[k]);
            if (lhs >= ab * thr) mag++;
        end
        return neg ? -mag : mag;
    endfunction

    // advance the predicted state by one accepted item, queue its steering command
    task automatic follow_item(t_item it);
        longint cx;
        longint cy;
        logic signed [255:0] d;
        logic signed [255:0] best;
        logic signed [255:0] lim;
        t_steer_cmd r;
        cx = longint'(it.x);
        cy = longint'(it.y);
        case (it.cmd)
            CMD_LOAD: begin
                // full table drops further loads
                if (wp_count < TABLE_DEPTH) begin
                    wp_x[wp_count] = cx;
                    wp_y[wp_count] = cy;
                    wp_count++;
                end
            end
            CMD_MODE: run_mode = it.mode;
            CMD_SAMPLE: begin
                // samples before any waypoint are dropped
                if (wp_count != 0) begin
                    // first sample: nearest waypoint, lowest index on a tie
                    if (!path_ready) begin
                        best = dist2(wp_x[0], wp_y[0], cx, cy);
                        target = 0;
                        for (int i = 1; i < wp_count; i++) begin
                            d = dist2(wp_x[i], wp_y[i], cx, cy);
                            if (d < best) begin
                                best = d;
                                target = i;
                            end
                        end
                        path_ready = 1'b1;
                    end
                    if (target >= wp_count) target = wp_count - 1;
                    if (run_mode == 8'd0) begin
                        r.steer = 6'(heading_error(prev_x, prev_y, cx, cy,
                                                   wp_x[target], wp_y[target]));
                        r.throttle = THROTTLE;
                        r.tidx = 10'(target);
                        if (it.typed) begin
                            r.steer = it.steer;
                            r.tidx = it.tidx;
                        end
                        steer_q = {steer_q, r};
                    end
                    // arrival moves the target on, saturating at the last waypoint
                    d = dist2(cx, cy, wp_x[target], wp_y[target]);
                    lim = 256'(longint'(arrive_dist) * longint'(arrive_dist));
                    if (d < lim && target + 1 < wp_count) target++;
                    // previous position follows once the move is large enough
                    d = dist2(cx, cy, prev_x, prev_y);
                    lim = 256'(longint'(refresh_dist) * longint'(refresh_dist));
                    if (d > lim) begin
                        prev_x = cx;
                        prev_y = cy;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // hand one item to the block, after random idle cycles when idle_on is set
    task automatic send_item(t_item it);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 36) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_cmd <= it.cmd;
        i_coord_x <= it.x;
        i_coord_y <= it.y;
        i_mode_value <= it.mode;
        do @(posedge i_clk); while (busy);
        follow_item(it);
        items_sent++;
    endtask

    // wait until the block has nothing left in flight
    task automatic drain();
        start <= 1'b0;
        while (steer_q.size() != 0) @(posedge i_clk);
        // a non-base sample gives no result but still runs for a while
        repeat (1000) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_ARRIVE) arrive_dist = value;
        else refresh_dist = value;
    endtask

    function automatic void add_row(t_cmd cmd, logic signed [39:0] x, logic signed [39:0] y,
                                    logic [7:0] mode, bit typed = 1'b0,
                                    logic signed [5:0] steer = '0, logic [9:0] tidx = '0);
        t_item it;
        it.cmd = cmd;
        it.x = x;
        it.y = y;
        it.mode = mode;
        it.typed = typed;
        it.steer = steer;
        it.tidx = tidx;
        directed = {directed, it};
    endfunction

    function automatic longint clip(longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    function automatic logic signed [39:0] any_coord();
        return 40'({$urandom, $urandom});
    endfunction

    function automatic longint jitter(int span);
        return longint'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // one random item; samples mostly walk toward the current target
    function automatic t_item random_item(bit loads_ok);
        t_item it;
        int pick;
        longint bx;
        longint by;
        pick = $urandom_range(0, 99);
        it.typed = 1'b0;
        it.steer = '0;
        it.tidx = '0;
        it.mode = 8'($urandom);
        it.x = any_coord();
        it.y = any_coord();
        if (pick < 30 && loads_ok) begin
            it.cmd = CMD_LOAD;
            // next waypoint within +/-4000 of the last one on each axis
            bx = (wp_count == 0) ? walk_x : wp_x[wp_count - 1];
            by = (wp_count == 0) ? walk_y : wp_y[wp_count - 1];
            it.x = 40'(clip(bx + jitter(4000)));
            it.y = 40'(clip(by + jitter(4000)));
        end else if (pick < 88) begin
            it.cmd = CMD_SAMPLE;
            if (wp_count != 0 && $urandom_range(0, 99) >= 3) begin
                bx = wp_x[(target < wp_count) ? target : wp_count - 1];
                by = wp_y[(target < wp_count) ? target : wp_count - 1];
                if ($urandom_range(0, 3) == 0) begin
                    // land on or near the target
                    walk_x = clip(bx + jitter(($urandom_range(0, 1) == 0) ? 0 : 1500));
                    walk_y = clip(by + jitter(1500));
                end else begin
                    walk_x = clip(walk_x + (bx - walk_x) / 2 + jitter(300));
                    walk_y = clip(walk_y + (by - walk_y) / 2 + jitter(300));
                end
                it.x = 40'(walk_x);
                it.y = 40'(walk_y);
            end
        end else if (pick < 93) begin
            it.cmd = CMD_MODE;
            if ($urandom_range(0, 1) == 0) it.mode = 8'd0;
        end else if (pick < 96) begin
            it.cmd = CMD_UNUSED;
        end else begin
            it.cmd = loads_ok ? CMD_LOAD : CMD_SAMPLE;
        end
        return it;
    endfunction

    // result checker: the receiver cannot stall, so every strobe is taken
    always @(posedge i_clk) begin
        t_steer_cmd e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (steer_q.size() == 0) begin
                $error("steering command with none expected");
                mismatches++;
            end else begin
                e = steer_q.pop_front();
                if (o_steering !== e.steer) begin
                    $error("steering: expected %0d, got %0d", e.steer, o_steering);
                    mismatches++;
                end
                if (o_throttle !== e.throttle) begin
                    $error("throttle: expected %0d, got %0d", e.throttle, o_throttle);
                    mismatches++;
                end
                if (o_target_index !== e.tidx) begin
                    $error("target_index: expected %0d, got %0d", e.tidx, o_target_index);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no progress on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_item it;
        int n_phase;
        start <= 1'b0;
        i_cmd <= CMD_LOAD;
        i_coord_x <= '0;
        i_coord_y <= '0;
        i_mode_value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        stall_cycles = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        idle_on = 1'b1;
        wp_count = 0;
        target = 0;
        path_ready = 1'b0;
        prev_x = 0;
        prev_y = 0;
        run_mode = 8'd0;
        arrive_dist = ARRIVE_RESET;
        refresh_dist = REFRESH_RESET;
        walk_x = 0;
        walk_y = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset register values
        add_row(CMD_SAMPLE, 40'sd5, 40'sd5, 8'h00);          // no waypoints yet: dropped
        add_row(CMD_UNUSED, COORD_MAX, COORD_MIN, 8'hFF);
        add_row(CMD_LOAD, 40'sd5000, 40'sd0, 8'h00);
        add_row(CMD_LOAD, 40'sd0, 40'sd1000, 8'hAA);
        add_row(CMD_LOAD, 40'sd0, -40'sd1000, 8'h55);        // ties with the one before
        add_row(CMD_LOAD, COORD_MAX, COORD_MAX, 8'h00);
        add_row(CMD_LOAD, COORD_MIN, COORD_MIN, 8'h00);
        // heading is zero length on the first samples; tie goes to the lower index
        add_row(CMD_SAMPLE, 40'sd0, 40'sd0, 8'h00, 1'b1, 6'sd0, 10'd1);
        add_row(CMD_SAMPLE, 40'sd0, 40'sd0, 8'h00, 1'b1, 6'sd0, 10'd2);
        add_row(CMD_SAMPLE, 40'sd1000, 40'sd0, 8'h00);
        add_row(CMD_MODE, 40'sd0, 40'sd0, 8'd7);
        add_row(CMD_SAMPLE, COORD_MAX, COORD_MAX - 40'sd3000, 8'h00);  // no result outside base
        add_row(CMD_MODE, 40'sd0, 40'sd0, 8'd0);
        // sitting on the target: zero length target vector
        add_row(CMD_SAMPLE, COORD_MAX, COORD_MAX, 8'h00, 1'b1, 6'sd0, 10'd3);
        add_row(CMD_SAMPLE, COORD_MIN, COORD_MAX, 8'h00);
        add_row(CMD_SAMPLE, COORD_MIN, COORD_MIN + 40'sd1, 8'h00);
        add_row(CMD_SAMPLE, 40'sd0, 40'sd0, 8'h00);          // target saturates
        add_row(CMD_SAMPLE, 40'sd0, COORD_MIN, 8'h00);
        add_row(CMD_SAMPLE, COORD_MAX, 40'sd0, 8'h00);
        add_row(CMD_MODE, 40'sd0, 40'sd0, 8'hFF);
        add_row(CMD_SAMPLE, 40'sd7, -40'sd9, 8'h00);
        add_row(CMD_MODE, 40'sd0, 40'sd0, 8'd0);
        foreach (directed[i]) send_item(directed[i]);
        walk_x = wp_x[wp_count - 1];
        walk_y = wp_y[wp_count - 1];

        // random phases, cycling through four register settings
        for (int p = 0; p < 8; p++) begin
            drain();
            case (p % 4)
                0: begin
                    write_reg(REG_ARRIVE, 16'hFFFF);
                    write_reg(REG_REFRESH, 16'd0);
                end
                1: begin
                    write_reg(REG_ARRIVE, 16'd0);
                    write_reg(REG_REFRESH, 16'hFFFF);
                end
                2: begin
                    write_reg(REG_ARRIVE, ARRIVE_RESET);
                    write_reg(REG_REFRESH, REFRESH_RESET);
                end
                default: begin
                    write_reg(REG_ARRIVE, 16'($urandom));
                    write_reg(REG_REFRESH, 16'($urandom_range(0, 2000)));
                end
            endcase
            // one phase runs with no gaps at all
            idle_on = (p != 1);
            n_phase = 100;
            for (int i = 0; i < n_phase; i++) begin
                it = random_item(1'b1);
                send_item(it);
            end
        end

        // fill the table to the top, then push a few loads past it
        drain();
        write_reg(REG_ARRIVE, 16'd3000);
        write_reg(REG_REFRESH, 16'd100);
        while (wp_count < TABLE_DEPTH) begin
            it = random_item(1'b1);
            it.cmd = CMD_LOAD;
            if (wp_count != 0) begin
                it.x = 40'(clip(wp_x[wp_count - 1] + jitter(4000)));
                it.y = 40'(clip(wp_y[wp_count - 1] + jitter(4000)));
            end
            send_item(it);
        end
        for (int i = 0; i < 40; i++) begin
            it = random_item(1'b0);
            if (i < 8) it.cmd = CMD_LOAD;
            send_item(it);
        end

        drain();
        repeat (7000) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (steer_q.size() != 0) begin
            $error("steering commands never delivered: %0d", steer_q.size());
            mismatches++;
        end
        $display("run: %0d items sent, %0d steering commands checked, %0d waypoints held",
                 items_sent, results_seen, wp_count);
        $display("settings covered: arrive/refresh at zero, full scale and reset values");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
